[hdl/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the C comment stripper: the input and result
// item formats, the scanner modes, the character codes and the queue sizes.
// ----------------------------------------------------------------------------
package ccs_pkg;

    // Input item: op = 0 carries a text byte, op = 1 marks the end of text.
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       stream_end;
        logic       last_in_run;
    } t_out_item;

    // Operation codes of the input item.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Scanner modes. Codes five to seven behave as normal text.
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4
    } t_mode;

    // Character codes.
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Result queue: an item causes at most two results.
    localparam int RES_DEPTH = 4;
    localparam int PTR_W     = $clog2(RES_DEPTH);
    localparam int LVL_W     = $clog2(RES_DEPTH + 1);
    localparam int MAX_RES   = 2;

    // Results produced by one item, in order, with their count.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  res0;
        t_out_item  res1;
    } t_push;

endpackage

[hdl/c_comment_stripper.sv]
// ----------------------------------------------------------------------------
// c_comment_stripper
// Byte-stream filter that removes line and block comments, leading whitespace
// and blank lines, and closes each text with an end marker.
// ----------------------------------------------------------------------------
// The block accepts one input item per clock cycle while the result queue has
// room. An accepted item waits in the input register until the scanner takes
// it, is scanned there combinationally, and its results (none, one or two)
// enter a four-entry result queue, which presents them on the output port.
// The output port hands out one result per cycle while the receiver is ready;
// an item that causes two results therefore occupies the output twice, and
// the input stalls only while the result queue holds more than two results.
module c_comment_stripper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ccs_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ccs_pkg::t_out_item  o_out_item
);
    import ccs_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              w_fire;
    logic              w_room;
    logic [LVL_W-1:0]  w_level;
    t_push             w_push;

    // The scanner runs only when the queue can take the largest result group.
    assign w_room     = (w_level <= LVL_W'(RES_DEPTH - MAX_RES));
    assign w_fire     = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Scanner.
    ccs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .o_push  (w_push)
    );

    // Result queue.
    ccs_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_level (w_level),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // The queue never holds more results than it has entries.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LVL_W'(RES_DEPTH))
        else $error("result queue overflow");

    // An end marker carries no byte and closes its item's results.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.stream_end) |->
            (!o_out_item.byte_valid && o_out_item.last_in_run))
        else $error("malformed end marker");

    // A held input item stays put until the scanner takes it.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input register lost an item");

    // Nothing enters the queue unless an item was scanned.
    a_push_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> w_fire)
        else $error("results pushed without an item");

endmodule

[hdl/ccs_step.sv]
// ----------------------------------------------------------------------------
// ccs_step
// Scanner state and the per-item update: decides the next mode and line flags
// and forms up to two result items for the item being processed.
// ----------------------------------------------------------------------------
module ccs_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ccs_pkg::t_in_item i_item,
    output ccs_pkg::t_push    o_push
);
    import ccs_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_line_content, n_line_content;
    logic  r_line_start, n_line_start;

    // Flags seen by the normal-text path, and its outcome.
    logic       nb_content;
    logic       nb_start;
    logic       nb_emit;
    logic       nb_run;
    logic       nb_ws;
    logic       slash_emit;
    t_out_item  slash_res;
    t_out_item  main_res;
    logic       main_emit;

    // Scanner update for one item.
    always_comb begin
        n_mode         = r_mode;
        n_line_content = r_line_content;
        n_line_start   = r_line_start;
        slash_emit     = 1'b0;
        main_emit      = 1'b0;
        main_res       = '0;
        nb_run         = 1'b0;
        nb_content     = r_line_content;
        nb_start       = r_line_start;
        nb_emit        = 1'b0;
        nb_ws          = (i_item.ch == CH_SP) || (i_item.ch == CH_TAB) || (i_item.ch == CH_CR);

        if (i_item.op == OP_END) begin
            // Flush a held slash, then mark the end and return to reset state.
            slash_emit          = (r_mode == MODE_SLASH);
            main_emit           = 1'b1;
            main_res.stream_end = 1'b1;
            n_mode              = MODE_NORMAL;
            n_line_content      = 1'b0;
            n_line_start        = 1'b1;
        end else begin
            unique case (r_mode)
                MODE_SLASH: begin
                    if (i_item.ch == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else if (i_item.ch == CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end else begin
                        // The held slash was text: emit it, then treat the byte normally.
                        slash_emit = 1'b1;
                        nb_content = 1'b1;
                        nb_start   = 1'b0;
                        n_mode     = MODE_NORMAL;
                        nb_run     = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (i_item.ch == CH_NL) begin
                        n_mode = MODE_NORMAL;
                        nb_run = 1'b1;
                    end
                end
                MODE_BLOCK: begin
                    if (i_item.ch == CH_STAR) begin
                        n_mode = MODE_STAR;
                    end
                end
                MODE_STAR: begin
                    if (i_item.ch == CH_SLASH) begin
                        n_mode = MODE_NORMAL;
                    end else if (i_item.ch != CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                    nb_run = 1'b1;
                end
            endcase

            // Normal-text handling of the byte.
            if (nb_run) begin
                n_line_content = nb_content;
                n_line_start   = nb_start;
                if (i_item.ch == CH_SLASH) begin
                    n_mode = MODE_SLASH;
                end else if (i_item.ch == CH_NL) begin
                    nb_emit        = nb_content;
                    n_line_content = 1'b0;
                    n_line_start   = 1'b1;
                end else if (nb_ws) begin
                    nb_emit = !nb_start;
                end else begin
                    nb_emit        = 1'b1;
                    n_line_content = 1'b1;
                    n_line_start   = 1'b0;
                end
                main_emit           = nb_emit;
                main_res.out_byte   = i_item.ch;
                main_res.byte_valid = 1'b1;
            end
        end
        main_res.last_in_run = 1'b1;
    end

    // Order the results: a flushed slash always comes first.
    always_comb begin
        slash_res             = '0;
        slash_res.out_byte    = CH_SLASH;
        slash_res.byte_valid  = 1'b1;
        slash_res.last_in_run = !main_emit;
        o_push                = '0;
        if (slash_emit) begin
            o_push.res0 = slash_res;
            o_push.res1 = main_res;
            o_push.cnt  = main_emit ? 2'd2 : 2'd1;
        end else begin
            o_push.res0 = main_res;
            o_push.cnt  = main_emit ? 2'd1 : 2'd0;
        end
        if (!i_fire) begin
            o_push.cnt = 2'd0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_NORMAL;
            r_line_content <= 1'b0;
            r_line_start   <= 1'b1;
        end else if (i_fire) begin
            r_mode         <= n_mode;
            r_line_content <= n_line_content;
            r_line_start   <= n_line_start;
        end
    end

endmodule

[hdl/ccs_res_queue.sv]
// ----------------------------------------------------------------------------
// ccs_res_queue
// Small result queue: takes up to two results per cycle and hands out one
// result per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module ccs_res_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ccs_pkg::t_push                 i_push,
    output logic [ccs_pkg::LVL_W-1:0]      o_level,
    output logic                           o_valid,
    input  logic                           i_ready,
    output ccs_pkg::t_out_item             o_item
);
    import ccs_pkg::*;

    t_out_item              r_mem [RES_DEPTH];
    logic [PTR_W-1:0]       r_wr, n_wr;
    logic [PTR_W-1:0]       r_rd, n_rd;
    logic [LVL_W-1:0]       r_level, n_level;
    logic                   w_pop;

    assign o_valid = (r_level != '0);
    assign o_item  = r_mem[r_rd];
    assign o_level = r_level;
    assign w_pop   = o_valid && i_ready;

    // Pointer and fill level update.
    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.cnt);
        n_rd    = r_rd + PTR_W'(w_pop);
        n_level = r_level + LVL_W'(i_push.cnt) - LVL_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.res1;
        end
    end

endmodule
